// ----- design/rc4_pkg.sv -----
`default_nettype none

package rc4_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned SBOX_DEPTH  = 256;
    localparam int unsigned KEY_WORDS   = 4;
    localparam int unsigned KEY_WORD_W  = 64;
    localparam int unsigned KLEN_W      = 6;
    localparam int unsigned KIDX_W      = 5;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned KEY_MAX_DEF = 32;

    localparam logic [KLEN_W-1:0] KLEN_RESET = KLEN_W'(32);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_0 = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_1 = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_2 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_3 = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH = CFG_IDX_W'(4);

    // Datapath operation for the current cycle.
    typedef enum logic [3:0] {
        OP_IDLE = 4'd0,
        OP_FILL = 4'd1,
        OP_KRDN = 4'd2,
        OP_KRDJ = 4'd3,
        OP_KWRN = 4'd4,
        OP_KWRJ = 4'd5,
        OP_PRDI = 4'd6,
        OP_PRDJ = 4'd7,
        OP_PWRI = 4'd8,
        OP_PWRJ = 4'd9,
        OP_POUT = 4'd10
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   load_in;
        logic   step_i;
        logic   clear_idx;
        logic   load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic i_last;
    } t_dp_sts;

endpackage

`default_nettype wire

// ----- design/rc4_ctrl.sv -----
`default_nettype none

module rc4_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire logic             i_restart,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output rc4_pkg::t_dp_cmd      o_cmd,
    input  wire rc4_pkg::t_dp_sts i_sts
);
    import rc4_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE = 11'b000_0000_0001,
        S_FILL = 11'b000_0000_0010,
        S_KRDN = 11'b000_0000_0100,
        S_KRDJ = 11'b000_0000_1000,
        S_KWRN = 11'b000_0001_0000,
        S_KWRJ = 11'b000_0010_0000,
        S_PRDI = 11'b000_0100_0000,
        S_PRDJ = 11'b000_1000_0000,
        S_PWRI = 11'b001_0000_0000,
        S_PWRJ = 11'b010_0000_0000,
        S_POUT = 11'b100_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_keyed;
    logic   n_keyed;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   accept;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign accept      = i_in_valid && o_in_ready;

    always_comb begin
        n_state         = r_state;
        n_keyed         = r_keyed;
        o_cmd.op        = OP_IDLE;
        o_cmd.load_in   = 1'b0;
        o_cmd.step_i    = 1'b0;
        o_cmd.clear_idx = 1'b0;
        o_cmd.load_out  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_cmd.op = OP_IDLE;
                if (accept) begin
                    o_cmd.load_in = 1'b1;
                    if (i_restart || !r_keyed) begin
                        o_cmd.clear_idx = 1'b1;
                        n_state         = S_FILL;
                    end else begin
                        o_cmd.step_i = 1'b1;
                        n_state      = S_PRDJ;
                    end
                end
            end
            S_FILL: begin
                o_cmd.op = OP_FILL;
                if (i_sts.i_last) begin
                    n_state = S_KRDN;
                end
            end
            S_KRDN: begin
                o_cmd.op = OP_KRDN;
                n_state  = S_KRDJ;
            end
            S_KRDJ: begin
                o_cmd.op = OP_KRDJ;
                n_state  = S_KWRN;
            end
            S_KWRN: begin
                o_cmd.op = OP_KWRN;
                n_state  = S_KWRJ;
            end
            S_KWRJ: begin
                o_cmd.op = OP_KWRJ;
                if (i_sts.i_last) begin
                    // Last swap of the schedule: i, j and the key index all restart at zero.
                    o_cmd.clear_idx = 1'b1;
                    n_keyed         = 1'b1;
                    n_state         = S_PRDI;
                end else begin
                    n_state = S_KRDN;
                end
            end
            S_PRDI: begin
                o_cmd.op     = OP_PRDI;
                o_cmd.step_i = 1'b1;
                n_state      = S_PRDJ;
            end
            S_PRDJ: begin
                o_cmd.op = OP_PRDJ;
                n_state  = S_PWRI;
            end
            S_PWRI: begin
                o_cmd.op = OP_PWRI;
                n_state  = S_PWRJ;
            end
            S_PWRJ: begin
                o_cmd.op = OP_PWRJ;
                n_state  = S_POUT;
            end
            S_POUT: begin
                o_cmd.op = OP_POUT;
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_keyed     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_keyed     <= n_keyed;
            r_out_valid <= n_out_valid;
        end
    end

    // An unkeyed block must run the key schedule before its first word.
    a_unkeyed_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && !r_keyed |=> r_state == S_FILL)
        else $error("first word after reset skipped the key schedule");

    // The keyed flag is only ever set by the final swap of the schedule.
    a_keyed_from_ks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_keyed) |-> $past(r_state) == S_KWRJ)
        else $error("keyed flag set outside the key schedule");

    // A finished word waits while the output register is still occupied.
    a_out_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_POUT && r_out_valid && !i_out_ready |=> r_state == S_POUT)
        else $error("result overwrote a word not yet taken");

endmodule

`default_nettype wire

// ----- design/rc4_dp.sv -----
`default_nettype none

module rc4_dp #(
    parameter int unsigned KEY_MAX_BYTES = rc4_pkg::KEY_MAX_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [rc4_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [rc4_pkg::KEY_WORD_W-1:0] i_cfg_data,
    input  wire logic [rc4_pkg::BYTE_W-1:0]   i_data_in,
    output logic [rc4_pkg::BYTE_W-1:0]        o_data_out,
    input  wire rc4_pkg::t_dp_cmd             i_cmd,
    output rc4_pkg::t_dp_sts                  o_sts
);
    import rc4_pkg::*;

    logic [KEY_WORD_W-1:0] r_key [KEY_WORDS];
    logic [KLEN_W-1:0]     r_key_len;

    logic [BYTE_W-1:0] r_sbox [SBOX_DEPTH];
    logic [BYTE_W-1:0] r_rdata;

    logic [BYTE_W-1:0] r_i, n_i;
    logic [BYTE_W-1:0] r_j, n_j;
    logic [KIDX_W-1:0] r_kidx, n_kidx;
    logic [BYTE_W-1:0] r_si, n_si;
    logic [BYTE_W-1:0] r_sj, n_sj;
    logic              r_hit, n_hit;
    logic [BYTE_W-1:0] r_data;
    logic [BYTE_W-1:0] r_out, n_out;

    logic [KLEN_W-1:0] klen;
    logic [BYTE_W-1:0] key_byte;
    logic [BYTE_W-1:0] acc_next;
    logic [BYTE_W-1:0] t_addr;
    logic [BYTE_W-1:0] mem_raddr;
    logic [BYTE_W-1:0] mem_waddr;
    logic [BYTE_W-1:0] mem_wdata;
    logic              mem_we;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < KEY_WORDS; k++) begin
                r_key[k] <= '0;
            end
            r_key_len <= KLEN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_KEY_WORD_0: r_key[0] <= i_cfg_data;
                REG_KEY_WORD_1: r_key[1] <= i_cfg_data;
                REG_KEY_WORD_2: r_key[2] <= i_cfg_data;
                REG_KEY_WORD_3: r_key[3] <= i_cfg_data;
                REG_KEY_LENGTH: r_key_len <= i_cfg_data[KLEN_W-1:0];
                default: ;
            endcase
        end
    end

    // A zero length acts as one; anything above KEY_MAX_BYTES saturates to it.
    always_comb begin
        if (r_key_len == '0) begin
            klen = KLEN_W'(1);
        end else if (r_key_len > KLEN_W'(KEY_MAX_BYTES)) begin
            klen = KLEN_W'(KEY_MAX_BYTES);
        end else begin
            klen = r_key_len;
        end
    end

    assign key_byte = r_key[r_kidx[KIDX_W-1:3]][{r_kidx[2:0], 3'b000} +: BYTE_W];
    assign acc_next = r_j + r_rdata + key_byte;
    assign t_addr   = r_si + r_sj;
    assign o_sts.i_last = (r_i == BYTE_W'(SBOX_DEPTH - 1));

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_i;
        mem_wdata = r_rdata;
        case (i_cmd.op)
            OP_IDLE, OP_PRDI: mem_raddr = r_i + BYTE_W'(1);
            OP_KRDJ:          mem_raddr = acc_next;
            OP_PRDJ:          mem_raddr = r_j + r_rdata;
            OP_PWRJ, OP_POUT: mem_raddr = t_addr;
            default:          mem_raddr = r_i;
        endcase
        case (i_cmd.op)
            OP_FILL: begin
                mem_we    = 1'b1;
                mem_wdata = r_i;
            end
            OP_KWRN, OP_PWRI: begin
                mem_we = 1'b1;
            end
            OP_KWRJ, OP_PWRJ: begin
                mem_we    = 1'b1;
                mem_waddr = r_j;
                mem_wdata = r_si;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_sbox[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_sbox[mem_raddr];
    end

    always_comb begin
        n_i    = r_i;
        n_j    = r_j;
        n_kidx = r_kidx;
        n_si   = r_si;
        n_sj   = r_sj;
        n_hit  = r_hit;
        n_out  = r_out;
        case (i_cmd.op)
            OP_FILL: n_i = r_i + BYTE_W'(1);
            OP_KRDJ: begin
                n_j  = acc_next;
                n_si = r_rdata;
            end
            OP_KWRJ: begin
                n_i = r_i + BYTE_W'(1);
                if ({1'b0, r_kidx} == klen - KLEN_W'(1)) begin
                    n_kidx = '0;
                end else begin
                    n_kidx = r_kidx + KIDX_W'(1);
                end
            end
            OP_PRDJ: begin
                n_j  = r_j + r_rdata;
                n_si = r_rdata;
            end
            OP_PWRI: n_sj = r_rdata;
            // The read of s[t] sees s[j] before its write lands in this cycle.
            OP_PWRJ: n_hit = (t_addr == r_j);
            default: ;
        endcase
        if (i_cmd.step_i) begin
            n_i = r_i + BYTE_W'(1);
        end
        if (i_cmd.clear_idx) begin
            n_i    = '0;
            n_j    = '0;
            n_kidx = '0;
        end
        if (i_cmd.load_out) begin
            n_out = r_data ^ (r_hit ? r_si : r_rdata);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i    <= '0;
            r_j    <= '0;
            r_kidx <= '0;
        end else begin
            r_i    <= n_i;
            r_j    <= n_j;
            r_kidx <= n_kidx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_si  <= n_si;
        r_sj  <= n_sj;
        r_hit <= n_hit;
        r_out <= n_out;
        if (i_cmd.load_in) begin
            r_data <= i_data_in;
        end
    end

    assign o_data_out = r_out;

endmodule

`default_nettype wire

// ----- design/rc4_stream_cipher.sv -----
`default_nettype none

// Channel   Handshake                   Payload
// input     i_in_valid / o_in_ready     i_data_in[7:0], i_restart
// output    o_out_valid / i_out_ready   o_data_out[7:0]
// config    i_cfg_we (no wait)          i_cfg_index[2:0], i_cfg_data[63:0]
//
// An accepted keyed word passes through PRDJ, PWRI, PWRJ and POUT and is written
// to the output register in POUT; the next word is taken only back in IDLE. The S-box
// memory with one read and one write port (reads of s[i] and s[j], two swap writes,
// read of s[t]) sets this sequence. A word that needs the key schedule first fills all
// 256 S-box entries, then makes the 256 schedule swaps, each through KRDN, KRDJ, KWRN
// and KWRJ, then reads s[1] in PRDI and follows the keyed path to the output register.
// Reset is synchronous and active low; the first word after reset always rekeys.
// A word is accepted while the previous result still waits in the output register.

module rc4_stream_cipher #(
    parameter int unsigned KEY_MAX_BYTES = rc4_pkg::KEY_MAX_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic [rc4_pkg::BYTE_W-1:0]     i_data_in,
    input  wire logic                           i_restart,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic [rc4_pkg::BYTE_W-1:0]          o_data_out,
    input  wire logic                           i_cfg_we,
    input  wire logic [rc4_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [rc4_pkg::KEY_WORD_W-1:0] i_cfg_data
);
    import rc4_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    rc4_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_restart   (i_restart),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    rc4_dp #(
        .KEY_MAX_BYTES (KEY_MAX_BYTES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_data_in   (i_data_in),
        .o_data_out  (o_data_out),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule

`default_nettype wire
